>>> hdl/mbbq_pkg.sv
// ----------------------------------------------------------------------------
// mbbq_pkg
// shared types and constants for the multi-bank biquad filter
// ----------------------------------------------------------------------------
package mbbq_pkg;

  // number of filter sections held in the state memory
  localparam int BANK_COUNT = 64;
  localparam int BANK_W     = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

  // operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // accumulator: products summed at 36 fraction bits, result keeps 8
  localparam int ACC_W     = 67;
  localparam int FRAC_DROP = 28;
  localparam int FF_ALIGN  = 8;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_DROP - 1);

  typedef struct packed {
    logic               operation;
    logic [5:0]         bank;
    logic signed [15:0] sample;
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_b1;
    logic signed [31:0] coef_b2;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;
  } item_t;

  typedef struct packed {
    logic [5:0]         out_bank;
    logic signed [31:0] filtered;
  } result_t;

  // everything one section keeps
  typedef struct packed {
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [15:0] x1;
    logic signed [15:0] x2;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
  } bank_state_t;

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
  } state_wr_t;

endpackage

>>> hdl/mbbq_state_mem.sv
// ----------------------------------------------------------------------------
// mbbq_state_mem
// per-bank state memory with valid bits and write-to-read bypass
// ----------------------------------------------------------------------------
module mbbq_state_mem
  import mbbq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [BANK_W-1:0] rd_bank,
  input  state_wr_t         wr,
  input  bank_state_t       wr_data,
  output bank_state_t       rd_data
);

  bank_state_t       mem [BANK_COUNT];
  logic [BANK_COUNT-1:0] filled;
  bank_state_t       rd_q;
  logic              rd_filled;
  logic              byp_hit;
  bank_state_t       byp_data;

  // storage and registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.bank] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_bank];
      byp_data <= wr_data;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
      byp_hit   <= 1'b0;
    end else begin
      if (wr.en) begin
        filled[wr.bank] <= 1'b1;
      end
      if (rd_en) begin
        rd_filled <= filled[rd_bank];
        byp_hit   <= wr.en && (wr.bank == rd_bank);
      end
    end
  end

  always_comb begin
    if (byp_hit) begin
      rd_data = byp_data;
    end else if (rd_filled) begin
      rd_data = rd_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

>>> hdl/mbbq_datapath.sv
// ----------------------------------------------------------------------------
// mbbq_datapath
// biquad arithmetic: five products, sum, round half up, saturate
// ----------------------------------------------------------------------------
module mbbq_datapath
  import mbbq_pkg::*;
(
  input  item_t              item,
  input  bank_state_t        st,
  output logic signed [31:0] y,
  output bank_state_t        st_next
);

  localparam int HI_W = ACC_W - FRAC_DROP - 31;

  logic signed [47:0]      p_b0;
  logic signed [47:0]      p_b1;
  logic signed [47:0]      p_b2;
  logic signed [63:0]      p_a1;
  logic signed [63:0]      p_a2;
  logic signed [49:0]      ff;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic [HI_W-1:0]         hi;

  assign p_b0 = $signed(st.b0) * $signed(item.sample);
  assign p_b1 = $signed(st.b1) * $signed(st.x1);
  assign p_b2 = $signed(st.b2) * $signed(st.x2);
  assign p_a1 = $signed(st.a1) * $signed(st.y1);
  assign p_a2 = $signed(st.a2) * $signed(st.y2);

  // feedforward terms carry 28 fraction bits, feedback terms 36
  assign ff  = 50'(p_b0) + 50'(p_b1) + 50'(p_b2);
  assign acc = (ACC_W'(ff) <<< FF_ALIGN) - ACC_W'(p_a1) - ACC_W'(p_a2);
  assign rnd = acc + ROUND_HALF;
  assign hi  = rnd[ACC_W-1:FRAC_DROP+31];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      y = rnd[FRAC_DROP+31:FRAC_DROP];
    end else if (rnd[ACC_W-1]) begin
      y = 32'sh8000_0000;
    end else begin
      y = 32'sh7fff_ffff;
    end
  end

  always_comb begin
    st_next = st;
    if (item.operation == OP_FILTER) begin
      st_next.x1 = item.sample;
      st_next.x2 = st.x1;
      st_next.y1 = y;
      st_next.y2 = st.y1;
    end else begin
      st_next.b0 = item.coef_b0;
      st_next.b1 = item.coef_b1;
      st_next.b2 = item.coef_b2;
      st_next.a1 = item.coef_a1;
      st_next.a2 = item.coef_a2;
    end
  end

endmodule

>>> hdl/multi_bank_biquad_filter_core.sv
// ----------------------------------------------------------------------------
// multi_bank_biquad_filter_core: bank of direct-form-I biquad sections
// a filter word is held in stage one, then its result is registered in the output register
// one word per cycle back to back while results are taken; loads leave no result
// bank state read at accept, arithmetic and write-back as the word leaves stage one, forwarded
// an output stall holds one word in stage one and one in the output register
// synchronous reset clears control and marks every bank's state as zero
// ----------------------------------------------------------------------------
module multi_bank_biquad_filter_core
  import mbbq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  // stage one: the accepted word together with its bank's state
  logic               s1_valid;
  item_t              s1_item;
  logic               s1_go;
  logic               s1_is_load;

  logic               accept;
  logic               in_range;

  state_wr_t          wr;
  bank_state_t        state;
  bank_state_t        state_next;
  logic signed [31:0] y;

  // a bank beyond the table is taken and dropped without effect
  assign in_range = (32'(item.bank) < 32'(BANK_COUNT));

  // a load leaves no result, so it never waits on the output register
  assign s1_is_load = (s1_item.operation == OP_LOAD);
  assign s1_go      = s1_valid && (s1_is_load || !result_valid || result_ready);
  assign item_ready = !s1_valid || s1_go;
  assign accept     = item_valid && item_ready;

  // state write-back happens as the word leaves stage one
  assign wr.en   = s1_go;
  assign wr.bank = s1_item.bank[BANK_W-1:0];

  mbbq_state_mem u_state_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_range),
    .rd_bank (item.bank[BANK_W-1:0]),
    .wr      (wr),
    .wr_data (state_next),
    .rd_data (state)
  );

  mbbq_datapath u_datapath (
    .item    (s1_item),
    .st      (state),
    .y       (y),
    .st_next (state_next)
  );

  // stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && in_range) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      s1_item <= item;
    end
  end

  // output register, refilled in the same cycle it is emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && !s1_is_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_is_load) begin
      result.out_bank <= s1_item.bank;
      result.filtered <= y;
    end
  end

`ifndef SYNTHESIS
  // a filtered word leaving stage one lands in the output register
  a_filter_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && !s1_is_load) |=> (result_valid && (result.out_bank == $past(s1_item.bank))))
    else $error("filter word did not reach the output register");

  // a held word in stage one is neither lost nor altered
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_item)))
    else $error("stalled stage one word changed");

  // back-to-back filter words on one bank see the bypassed input delay
  a_bypass_x1: assert property (@(posedge clk) disable iff (rst)
    (s1_go && !s1_is_load && accept && in_range && (item.bank == s1_item.bank))
      |=> (state.x1 == $past(s1_item.sample)))
    else $error("input delay not forwarded to following word");
`endif

endmodule
